// ----- hw/rtl/lso_pkg.sv -----
// Package for the laser scan occupancy grid: grid geometry, fixed-point widths,
// the arctangent table and the per-cell angle tables built at elaboration.
// Depends on nothing; every other file of the block imports it.
package lso_pkg;

	localparam int GRID_COLS       = 40;
	localparam int GRID_ROWS       = 30;
	localparam int BEAM_COUNT      = 720;
	localparam int CELLS_PER_METRE = 2;

	localparam int CELL_Q8      = 256 / CELLS_PER_METRE;
	localparam int MAX_RANGE_Q8 = (GRID_COLS / 2) * CELL_Q8;
	localparam int HALF_Q10     = 184320;
	localparam int RIGHT_Q10    = 92160;
	localparam int ANG_STEP     = HALF_Q10 / BEAM_COUNT;
	localparam int STEPS        = 22;
	localparam longint GAIN_Q30 = 652032874;

	localparam int RANGE_W   = 16;
	localparam int BEAM_W    = 10;
	localparam int ROW_OUT_W = 5;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int R_W       = $clog2(MAX_RANGE_Q8 + 1);
	localparam int ANG_W     = 18;
	localparam int BIDX_W    = 11;
	localparam int COORD_W   = 16;
	localparam int ATAN_W    = 22;
	localparam int STEP_W    = 5;

	typedef logic [GRID_ROWS-1:0][GRID_COLS-1:0][ANG_W-1:0]  ang_tab_t;
	typedef logic [GRID_ROWS-1:0][GRID_COLS-1:0][BIDX_W-1:0] bidx_tab_t;

	typedef struct packed {
		logic             prep;
		logic             mark;
		logic             clear;
		logic [ROW_W-1:0] row;
	} grid_ctrl_t;

	// atan(2^-k) in units of 2^-16 degree.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] k);
		logic [ATAN_W-1:0] v;
		unique case (k)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Angle of a grid corner in 1/1024 degree, y >= 0, by vectoring CORDIC.
	function automatic longint angle_of(input longint x, input longint y);
		longint cx, cy, z, q, nx, ny;
		if (y == 0) return (x < 0) ? HALF_Q10 : 0;
		if (x == 0) return RIGHT_Q10;
		cx = ((x < 0) ? -x : x) * 65536;
		cy = y * 65536;
		z  = 0;
		for (int k = 0; k < STEPS; k++) begin
			if (cy >= 0) begin
				nx = cx + (cy >>> k);
				ny = cy - (cx >>> k);
				z  = z + longint'(atan_q16(STEP_W'(k)));
			end else begin
				nx = cx - (cy >>> k);
				ny = cy + (cx >>> k);
				z  = z - longint'(atan_q16(STEP_W'(k)));
			end
			cx = nx;
			cy = ny;
		end
		q = (z + 32) >>> 6;
		if (q < 0) q = 0;
		if (q > RIGHT_Q10) q = RIGHT_Q10;
		return (x < 0) ? HALF_Q10 - q : q;
	endfunction

	function automatic longint cell_begin(input int r, input int c);
		longint cx, cy;
		cx = longint'(c) * CELL_Q8 - MAX_RANGE_Q8;
		cy = longint'(r) * CELL_Q8;
		return (cx < 0) ? angle_of(cx + CELL_Q8, cy + CELL_Q8) : angle_of(cx + CELL_Q8, cy);
	endfunction

	function automatic longint cell_end(input int r, input int c);
		longint cx, cy;
		cx = longint'(c) * CELL_Q8 - MAX_RANGE_Q8;
		cy = longint'(r) * CELL_Q8;
		return (cx < 0) ? angle_of(cx, cy) : angle_of(cx, cy + CELL_Q8);
	endfunction

	function automatic ang_tab_t build_begin();
		ang_tab_t t;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				t[r][c] = ANG_W'(cell_begin(r, c));
		return t;
	endfunction

	function automatic ang_tab_t build_end();
		ang_tab_t t;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				t[r][c] = ANG_W'(cell_end(r, c));
		return t;
	endfunction

	// First beam whose angle bucket reaches the cell.
	function automatic bidx_tab_t build_first();
		bidx_tab_t t;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				t[r][c] = BIDX_W'(cell_begin(r, c) * BEAM_COUNT / HALF_Q10);
		return t;
	endfunction

	// One past the last beam that reaches the cell.
	function automatic bidx_tab_t build_stop();
		bidx_tab_t t;
		for (int r = 0; r < GRID_ROWS; r++)
			for (int c = 0; c < GRID_COLS; c++)
				t[r][c] = BIDX_W'((cell_end(r, c) * BEAM_COUNT + HALF_Q10 - 1) / HALF_Q10);
		return t;
	endfunction

	localparam ang_tab_t  CELL_BEGIN = build_begin();
	localparam ang_tab_t  CELL_END   = build_end();
	localparam bidx_tab_t CELL_FIRST = build_first();
	localparam bidx_tab_t CELL_STOP  = build_stop();

endpackage

// ----- hw/rtl/lso_cordic.sv -----
// Iterative rotation CORDIC that turns a range and beam angle into an endpoint.
// One micro-rotation per cycle through a single shared add/shift unit; uses lso_pkg.
module lso_cordic
	import lso_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [R_W-1:0]            range_in,
	input  logic [ANG_W-1:0]          ang,
	output logic                      done,
	output logic signed [COORD_W-1:0] ex,
	output logic signed [COORD_W-1:0] ey
);

	localparam int XW = 44;
	localparam int ZW = 26;

	logic signed [XW-1:0]      x_q, y_q, nx, ny, xr, yr;
	logic signed [ZW-1:0]      z_q, nz, atan_s;
	logic [STEP_W-1:0]         k_q;
	logic                      busy_q, done_q, mirror_q;
	logic                      mirror;
	logic [ANG_W-1:0]          fold;
	logic signed [COORD_W-1:0] ex_q, ey_q, px, py, r_s;

	assign mirror = (ang > ANG_W'(RIGHT_Q10));
	assign fold   = mirror ? ANG_W'(HALF_Q10) - ang : ang;
	assign r_s    = signed'(COORD_W'(range_in));
	assign atan_s = signed'(ZW'(atan_q16(k_q)));

	always_comb begin
		if (z_q >= 0) begin
			nx = x_q - (y_q >>> k_q);
			ny = y_q + (x_q >>> k_q);
			nz = z_q - atan_s;
		end else begin
			nx = x_q + (y_q >>> k_q);
			ny = y_q - (x_q >>> k_q);
			nz = z_q + atan_s;
		end
		xr = nx + signed'(XW'(longint'(1) <<< 29));
		yr = ny + signed'(XW'(longint'(1) <<< 29));
		px = signed'(COORD_W'(xr >>> 30));
		py = signed'(COORD_W'(yr >>> 30));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			k_q      <= '0;
			mirror_q <= 1'b0;
		end else begin
			// The axis angles finish at once; others after the last micro-rotation.
			done_q <= start ? (fold == '0 || fold >= ANG_W'(RIGHT_Q10))
			                : (busy_q && k_q == STEP_W'(STEPS - 1));
			if (start) begin
				mirror_q <= mirror;
				if (fold == '0) begin
					ex_q   <= mirror ? -r_s : r_s;
					ey_q   <= '0;
				end else if (fold >= ANG_W'(RIGHT_Q10)) begin
					ex_q   <= '0;
					ey_q   <= r_s;
				end else begin
					x_q    <= signed'(XW'(longint'(range_in) * GAIN_Q30));
					y_q    <= '0;
					z_q    <= signed'(ZW'({fold, 6'd0}));
					k_q    <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				x_q <= nx;
				y_q <= ny;
				z_q <= nz;
				k_q <= k_q + 1'b1;
				if (k_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					ex_q   <= mirror_q ? -px : px;
					ey_q   <= py;
				end
			end
		end
	end

	assign done = done_q;
	assign ex   = ex_q;
	assign ey   = ey_q;

endmodule

// ----- hw/rtl/lso_grid.sv -----
// Occupied and shadow bitmaps with the row-parallel cell compare that marks them.
// Uses the cell angle tables of lso_pkg; driven by the sequencer in the top level.
module lso_grid
	import lso_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  grid_ctrl_t                ctrl,
	input  logic signed [COORD_W-1:0] ex,
	input  logic signed [COORD_W-1:0] ey,
	input  logic [ANG_W-1:0]          ang,
	input  logic [BEAM_W-1:0]         beam,
	output logic [GRID_COLS-1:0]      occ_rd,
	output logic [GRID_COLS-1:0]      shd_rd
);

	logic [GRID_COLS-1:0]      occ_q [GRID_ROWS];
	logic [GRID_COLS-1:0]      shd_q [GRID_ROWS];
	logic [GRID_COLS-1:0]      occ_col_q, shd_col_q, occ_col, shd_col;
	logic [GRID_COLS-1:0]      occ_new, shd_new;
	logic signed [COORD_W-1:0] sy_q, cy, cx, fl_x, cl_x;
	logic [BIDX_W-1:0]         beam_x;
	logic                      row_in, row_far;

	assign fl_x   = ex & ~COORD_W'(255);
	assign cl_x   = (ex + COORD_W'(255)) & ~COORD_W'(255);
	assign beam_x = BIDX_W'(beam);
	assign cy     = signed'(COORD_W'(int'(ctrl.row) * CELL_Q8));
	assign row_in = (ey >= cy) && (ey <= cy + signed'(COORD_W'(CELL_Q8)));
	assign row_far = (cy >= sy_q);

	always_comb begin
		cx = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			cx = signed'(COORD_W'(c * CELL_Q8 - MAX_RANGE_Q8));
			occ_col[c] = (ex >= cx) && (ex <= cx + signed'(COORD_W'(CELL_Q8)));
			shd_col[c] = (ex < 0) ? (cx < cl_x) : (cx >= fl_x);
			occ_new[c] = row_in && occ_col_q[c] &&
			             (beam_x >= CELL_FIRST[ctrl.row][c]) &&
			             (beam_x <  CELL_STOP[ctrl.row][c]);
			shd_new[c] = row_far && shd_col_q[c] &&
			             (CELL_BEGIN[ctrl.row][c] < ang) &&
			             (CELL_END[ctrl.row][c] > ang);
		end
	end

	assign occ_rd = occ_q[ctrl.row];
	assign shd_rd = shd_q[ctrl.row];

	always_ff @(posedge clk) begin
		if (ctrl.prep) begin
			occ_col_q <= occ_col;
			shd_col_q <= shd_col;
			sy_q      <= ey & ~COORD_W'(255);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_ROWS; r++) begin
				occ_q[r] <= '0;
				shd_q[r] <= '0;
			end
		end else if (ctrl.mark) begin
			occ_q[ctrl.row] <= occ_q[ctrl.row] | occ_new;
			shd_q[ctrl.row] <= shd_q[ctrl.row] | shd_new;
		end else if (ctrl.clear) begin
			occ_q[ctrl.row] <= '0;
			shd_q[ctrl.row] <= '0;
		end
	end

endmodule

// ----- hw/rtl/laser_scan_occupancy_grid.sv -----
// Top level of the laser scan occupancy grid: sequencer, range clamp and output register.
// Instantiates lso_cordic and lso_grid; uses lso_pkg.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  range_value, beam_number, last_beam
//   out      source     out_valid/out_stall  row_number, occupied_bits, shadow_bits, last_row
//   cfg      sink       cfg_we               cfg_wdata (min_range)
//
// An in-range beam is accepted, then rotated by the CORDIC (no micro-rotations if the angle is 0 or
// 90 degrees), then its column masks are latched and the rows are marked in turn; the
// shared CORDIC step and the one-row-per-cycle walk over the bitmaps set its duration.
// A beam with last_beam set is then followed by 30 output transactions, one per row,
// each of which waits while out_stall is high. in_stall is high whenever the sequencer
// is busy. Reset clears both bitmaps, min_range and all control state at once.
module laser_scan_occupancy_grid
	import lso_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [RANGE_W-1:0]    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RANGE_W-1:0]    range_value,
	input  logic [BEAM_W-1:0]     beam_number,
	input  logic                  last_beam,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ROW_OUT_W-1:0]  row_number,
	output logic [GRID_COLS-1:0]  occupied_bits,
	output logic [GRID_COLS-1:0]  shadow_bits,
	output logic                  last_row
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_MARK,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [RANGE_W-1:0]        min_range_q;
	logic [R_W-1:0]            range_q;
	logic [BEAM_W-1:0]         beam_q;
	logic [ANG_W-1:0]          ang_q;
	logic                      last_q, start_q;
	logic [ROW_W-1:0]          row_q;
	logic                      out_valid_q, last_row_q;
	logic [ROW_OUT_W-1:0]      row_number_q;
	logic [GRID_COLS-1:0]      occ_out_q, shd_out_q, occ_rd, shd_rd;
	logic                      accept, emit_go, cordic_done;
	logic signed [COORD_W-1:0] ex, ey;
	grid_ctrl_t                ctrl;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// During emission, an output row is loaded whenever the output register is empty or being taken.
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		ctrl.prep  = cordic_done;
		ctrl.mark  = (state_q == ST_MARK);
		ctrl.clear = emit_go;
		// Emission reads the farthest row first.
		ctrl.row   = (state_q == ST_EMIT) ? ROW_W'(GRID_ROWS - 1) - row_q : row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= '0;
		end else if (cfg_we) begin
			min_range_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			start_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Only an in-range beam needs the endpoint unit.
			start_q <= accept && (beam_number < BEAM_W'(BEAM_COUNT));
			if (emit_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Ranges at or below min_range or at or beyond the grid edge count as max range.
						if (range_value <= min_range_q ||
						    range_value >= RANGE_W'(MAX_RANGE_Q8))
							range_q <= R_W'(MAX_RANGE_Q8);
						else
							range_q <= R_W'(range_value);
						beam_q <= beam_number;
						ang_q  <= ANG_W'(beam_number) * ANG_W'(ANG_STEP);
						last_q <= last_beam;
						row_q  <= '0;
						if (beam_number < BEAM_W'(BEAM_COUNT)) begin
							state_q <= ST_ROT;
						end else if (last_beam) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ROT: begin
					if (cordic_done) state_q <= ST_MARK;
				end
				ST_MARK: begin
					if (row_q == ROW_W'(GRID_ROWS - 1)) begin
						row_q   <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						row_number_q <= ROW_OUT_W'(row_q);
						occ_out_q    <= occ_rd;
						shd_out_q    <= shd_rd;
						last_row_q   <= (row_q == ROW_W'(GRID_ROWS - 1));
						if (row_q == ROW_W'(GRID_ROWS - 1)) begin
							row_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	lso_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.range_in (range_q),
		.ang      (ang_q),
		.done     (cordic_done),
		.ex       (ex),
		.ey       (ey)
	);

	lso_grid u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.ex     (ex),
		.ey     (ey),
		.ang    (ang_q),
		.beam   (beam_q),
		.occ_rd (occ_rd),
		.shd_rd (shd_rd)
	);

	assign out_valid     = out_valid_q;
	assign row_number    = row_number_q;
	assign occupied_bits = occ_out_q;
	assign shadow_bits   = shd_out_q;
	assign last_row      = last_row_q;

	// The final row of a burst always carries the last row number.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_row_q |-> row_number_q == ROW_OUT_W'(GRID_ROWS - 1))
		else $error("last_row set on a row other than the final one");

	// The endpoint unit only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == ST_ROT)
		else $error("CORDIC result arrived outside the rotation phase");

	// An accepted in-range beam always starts the rotation next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && beam_number < BEAM_W'(BEAM_COUNT) |=> start_q && state_q == ST_ROT)
		else $error("accepted beam did not start the rotation");

	// The row counter never leaves the grid.
	assert property (@(posedge clk) disable iff (!arst_n)
		row_q < ROW_W'(GRID_ROWS))
		else $error("row counter beyond the grid");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the laser scan occupancy grid.
// A clocked driver and monitor run against an in-bench model of the grid; the package
// lso_pkg supplies only the geometry and CORDIC constants and the port widths.
module tb;
	import lso_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_CYCLES    = 700;
	localparam int SETTLE_CYCLES  = 120;

	typedef struct {
		logic [RANGE_W-1:0] range_q8;
		logic [BEAM_W-1:0]  beam;
		logic               last;
	} beam_sample_t;

	typedef struct {
		logic [ROW_OUT_W-1:0] row;
		logic [GRID_COLS-1:0] occ;
		logic [GRID_COLS-1:0] shd;
		logic                 last;
	} grid_row_t;

	// atan(2^-k) in 2^-16 degree.
	localparam longint ATAN_STEP [STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
		4, 2};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RANGE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [RANGE_W-1:0] range_value = '0;
	logic [BEAM_W-1:0] beam_number = '0;
	logic last_beam = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ROW_OUT_W-1:0] row_number;
	logic [GRID_COLS-1:0] occupied_bits;
	logic [GRID_COLS-1:0] shadow_bits;
	logic last_row;

	beam_sample_t pending_beams[$];
	grid_row_t    expected_rows[$];
	longint       corner_angle[GRID_ROWS+1][GRID_COLS+1];
	logic [GRID_COLS-1:0] occ_map[GRID_ROWS];
	logic [GRID_COLS-1:0] shd_map[GRID_ROWS];
	longint min_range_q8 = 0;
	int  error_count = 0;
	int  hold_requests = 0;
	bit  no_idle = 1'b0;

	laser_scan_occupancy_grid uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .range_value(range_value),
		.beam_number(beam_number), .last_beam(last_beam), .out_valid(out_valid),
		.out_stall(out_stall), .row_number(row_number), .occupied_bits(occupied_bits),
		.shadow_bits(shadow_bits), .last_row(last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Whole-metre rounding of a Q8 length, toward minus infinity.
	function automatic longint metre_floor(input longint v);
		return (v >= 0) ? (v / 256) * 256 : -(((-v) + 255) / 256) * 256;
	endfunction

	// Vectoring CORDIC: angle of (x, y), y >= 0, in 1/1024 degree.
	function automatic longint vector_angle(input longint x, input longint y);
		longint vx, vy, z, nx, ny, q;
		if (y == 0) return (x < 0) ? HALF_Q10 : 0;
		if (x == 0) return RIGHT_Q10;
		vx = ((x < 0) ? -x : x) * 65536;
		vy = y * 65536;
		z = 0;
		for (int k = 0; k < STEPS; k++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> k);
				ny = vy - (vx >>> k);
				z += ATAN_STEP[k];
			end else begin
				nx = vx - (vy >>> k);
				ny = vy + (vx >>> k);
				z -= ATAN_STEP[k];
			end
			vx = nx;
			vy = ny;
		end
		q = (z + 32) >>> 6;
		if (q < 0) q = 0;
		if (q > RIGHT_Q10) q = RIGHT_Q10;
		return (x < 0) ? HALF_Q10 - q : q;
	endfunction

	// Rotation CORDIC: endpoint of a beam of length r at angle a (1/1024 degree).
	task automatic beam_endpoint(input longint r, input longint a, output longint ex,
		output longint ey);
		bit mirror;
		longint f, vx, vy, z, nx, ny, px, py;
		mirror = a > RIGHT_Q10;
		f = mirror ? HALF_Q10 - a : a;
		if (f <= 0) begin
			px = r;
			py = 0;
		end else if (f >= RIGHT_Q10) begin
			px = 0;
			py = r;
		end else begin
			vx = r * GAIN_Q30;
			vy = 0;
			z = f * 64;
			for (int k = 0; k < STEPS; k++) begin
				if (z >= 0) begin
					nx = vx - (vy >>> k);
					ny = vy + (vx >>> k);
					z -= ATAN_STEP[k];
				end else begin
					nx = vx + (vy >>> k);
					ny = vy - (vx >>> k);
					z += ATAN_STEP[k];
				end
				vx = nx;
				vy = ny;
			end
			px = (vx + (longint'(1) << 29)) >>> 30;
			py = (vy + (longint'(1) << 29)) >>> 30;
		end
		ex = mirror ? -px : px;
		ey = py;
	endtask

	// Marks one accepted beam into the model bitmaps and, on the last beam of a scan,
	// queues the 30 rows the block must emit and clears the maps.
	task automatic rasterize_beam(input beam_sample_t s);
		longint r, a, ex, ey, sx, ex_end, sy, cx, cy, b, e, bi, ei, beam;
		beam = s.beam;
		if (beam < BEAM_COUNT) begin
			r = s.range_q8;
			if (r <= min_range_q8 || r >= MAX_RANGE_Q8) r = MAX_RANGE_Q8;
			a = beam * HALF_Q10 / BEAM_COUNT;
			beam_endpoint(r, a, ex, ey);
			if (ex < 0) begin
				sx = -MAX_RANGE_Q8;
				ex_end = -metre_floor(-ex);
			end else begin
				sx = metre_floor(ex);
				ex_end = MAX_RANGE_Q8;
			end
			sy = metre_floor(ey);
			for (int row = 0; row < GRID_ROWS; row++) begin
				cy = longint'(row) * CELL_Q8;
				for (int col = 0; col < GRID_COLS; col++) begin
					cx = longint'(col) * CELL_Q8 - MAX_RANGE_Q8;
					if (cx < 0) begin
						b = corner_angle[row+1][col+1];
						e = corner_angle[row][col];
					end else begin
						b = corner_angle[row][col+1];
						e = corner_angle[row+1][col];
					end
					if (ex >= cx && ex <= cx + CELL_Q8 && ey >= cy && ey <= cy + CELL_Q8) begin
						bi = b * BEAM_COUNT / HALF_Q10;
						ei = (e * BEAM_COUNT + HALF_Q10 - 1) / HALF_Q10;
						if (beam >= bi && beam < ei) occ_map[row][col] = 1'b1;
					end
					if (cx >= sx && cx < ex_end && cy >= sy && cy < GRID_ROWS * CELL_Q8 &&
						b < a && e > a)
						shd_map[row][col] = 1'b1;
				end
			end
		end
		if (s.last) begin
			for (int k = 0; k < GRID_ROWS; k++) begin
				expected_rows.push_back('{ROW_OUT_W'(k), occ_map[GRID_ROWS-1-k],
					shd_map[GRID_ROWS-1-k], k == GRID_ROWS - 1});
			end
			for (int row = 0; row < GRID_ROWS; row++) begin
				occ_map[row] = '0;
				shd_map[row] = '0;
			end
		end
	endtask

	// Driver: presents queued beams, with random gaps between transactions.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) rasterize_beam('{range_value, beam_number, last_beam});
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_beams.size() > 0) begin
					beam_sample_t s;
					s = pending_beams.pop_front();
					in_valid <= 1'b1;
					range_value <= s.range_q8;
					beam_number <= s.beam;
					last_beam <= s.last;
					if (no_idle || $urandom_range(0, 2) != 0) send_gap <= 0;
					else if ($urandom_range(0, 11) == 0) send_gap <= $urandom_range(20, 80);
					else send_gap <= $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted row and drives a random stall pattern. A hold-off
	// request from the stimulus makes it stall for a long stretch counted here.
	int stall_left = 0;
	int holds_served = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_rows.size() == 0) begin
					$error("unexpected row transaction, row_number %0d", row_number);
					error_count++;
				end else begin
					grid_row_t x;
					x = expected_rows.pop_front();
					if (row_number !== x.row) begin
						$error("row_number expected %0d actual %0d", x.row, row_number);
						error_count++;
					end
					if (occupied_bits !== x.occ) begin
						$error("occupied_bits expected %h actual %h", x.occ, occupied_bits);
						error_count++;
					end
					if (shadow_bits !== x.shd) begin
						$error("shadow_bits expected %h actual %h", x.shd, shadow_bits);
						error_count++;
					end
					if (last_row !== x.last) begin
						$error("last_row expected %0d actual %0d", x.last, last_row);
						error_count++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				stall_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (no_idle || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left <= ($urandom_range(0, 14) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 3);
			end
		end
	end

	// Watchdog: a stretch with no transaction on either channel ends the run.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_beam(input int rng, input int beam, input bit last);
		pending_beams.push_back('{RANGE_W'(rng), BEAM_W'(beam), last});
	endtask

	// One well-formed scan of random content: beams mostly ascending, a few bad indexes.
	task automatic add_scan(input int beams);
		int b, rng;
		b = $urandom_range(0, 40);
		for (int i = 0; i < beams; i++) begin
			case ($urandom_range(0, 9))
				0: rng = $urandom_range(0, 65535);
				1: rng = $urandom_range(0, 300);
				2: rng = $urandom_range(5100, 5140);
				default: rng = $urandom_range(128, 5119);
			endcase
			if ($urandom_range(0, 19) == 0) add_beam(rng, $urandom_range(720, 1023), i == beams - 1);
			else add_beam(rng, b, i == beams - 1);
			b += $urandom_range(1, 60);
			if (b > 719) b = $urandom_range(0, 719);
		end
	endtask

	// Waits for the block to drain, then writes min_range.
	task automatic write_min_range(input int v);
		wait (pending_beams.size() == 0 && !in_valid && expected_rows.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= RANGE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		min_range_q8 = v;
	endtask

	initial begin
		for (int j = 0; j <= GRID_ROWS; j++)
			for (int i = 0; i <= GRID_COLS; i++)
				corner_angle[j][i] = vector_angle(longint'(i) * CELL_Q8 - MAX_RANGE_Q8,
					longint'(j) * CELL_Q8);
		for (int row = 0; row < GRID_ROWS; row++) begin
			occ_map[row] = '0;
			shd_map[row] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed scans: straight right, straight ahead, the leftmost beam, zero and full
		// scale ranges, the exact min_range clamp limit, bad beam indexes and a last beam
		// with a bad index.
		write_min_range(0);
		add_beam(0, 0, 0);
		add_beam(65535, 360, 0);
		add_beam(5119, 719, 0);
		add_beam(5120, 1, 0);
		add_beam(1000, 180, 0);
		add_beam(1000, 180, 0);
		add_beam(300, 540, 0);
		add_beam(64, 1023, 0);
		add_beam(2000, 720, 0);
		add_beam(3072, 512, 1);
		add_beam(128, 90, 0);
		add_beam(21845, 341, 0);
		add_beam(43690, 682, 0);
		add_beam(256, 1023, 1);
		write_min_range(65535);
		add_beam(65534, 100, 0);
		add_beam(1, 300, 1);
		write_min_range(1000);
		add_beam(1000, 200, 0);
		add_beam(1001, 250, 0);
		add_beam(999, 600, 1);

		// Random scans, each phase under its own min_range.
		write_min_range($urandom_range(1, 4000));
		repeat (3) add_scan($urandom_range(10, 30));
		write_min_range(0);
		hold_requests = hold_requests + 1;
		repeat (3) add_scan($urandom_range(10, 30));
		write_min_range(65535);
		repeat (2) add_scan($urandom_range(5, 15));
		write_min_range($urandom_range(0, 65535));
		no_idle = 1'b1;
		repeat (3) add_scan($urandom_range(10, 30));
		wait (pending_beams.size() == 0 && !in_valid && expected_rows.size() == 0);
		no_idle = 1'b0;
		write_min_range($urandom_range(100, 600));
		repeat (4) add_scan($urandom_range(10, 30));
		write_min_range(0);
		repeat (3) add_scan($urandom_range(10, 30));

		wait (pending_beams.size() == 0 && !in_valid && expected_rows.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_rows.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
